/* hw/rtl/icc_pkg.sv */
// shared constants for the iteration count colorizer
// register indexes, count limits and parameter defaults; no dependencies
package icc_pkg;

  localparam int unsigned DEF_PALETTE_DEPTH = 1024;
  localparam int unsigned DEF_MAX_AA        = 4;

  localparam logic [2:0] CFG_MAX_ITERS   = 3'd0;
  localparam logic [2:0] CFG_ITER_WIDE   = 3'd1;
  localparam logic [2:0] CFG_AA_FACTOR   = 3'd2;
  localparam logic [2:0] CFG_GREY_MODE   = 3'd3;
  localparam logic [2:0] CFG_AUX_DEPTH   = 3'd4;
  localparam logic [2:0] CFG_ROTATION    = 3'd5;
  localparam logic [2:0] CFG_PAL_SIZE    = 3'd6;

  localparam logic [63:0] LIMIT_NARROW = 64'd2147483646;
  localparam logic [63:0] LIMIT_WIDE   = 64'd9223372036854775806;

  localparam logic [62:0] MAX_ITERS_RST = 63'd256;
  localparam logic [16:0] GREY_NUM      = 17'h10000;
  localparam logic [16:0] GREY_RST      = 17'd256;
  localparam logic [15:0] ALPHA_OPAQUE  = 16'hFFFF;

endpackage

/* hw/rtl/icc_ram.sv */
// generic single write port ram with registered read
// no dependencies
module icc_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/icc_sdiv.sv */
// bit serial restoring divider, one quotient bit per cycle
// gives quotient and remainder; no dependencies
module icc_sdiv #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o,
  output logic [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[NumW-1]};
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenW'(trial - {1'b0, den_q});
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

/* hw/rtl/iteration_count_colorizer_unit.sv */
// iteration count colorizer top level: samples to averaged rgba pixels
// uses icc_pkg, icc_ram and icc_sdiv
//
// usage
//   s_axis carries one transaction per sample or palette write; tuser is the
//   command (0 sample, 1 palette write). m_axis carries one 64-bit rgba pixel
//   after every aa_factor squared samples; alpha is always 65535.
//   cfg_we_i/cfg_addr_i/cfg_wdata_i write one register per cycle; the user
//   must write only while the block is idle; the block does not enforce it.
//   a max_iters write of 1..65536 starts a grey scale divide, tready low till done.
// processing
//   a palette write is taken straight from idle. a sample goes through prep,
//   shift and select; an unescaped sample in palette mode then takes the
//   64-step serial modulo by the palette size and a palette read. the last
//   sample of a pixel adds a serial divide by aa squared of one cycle per sum
//   bit (21 by default). one transaction is in work at a time.
// reset
//   sums and sample count clear, registers take their defaults, the grey
//   scale is 256. palette contents are undefined until written.
// back pressure
//   a finished pixel sits in the output register; the next transaction is
//   taken meanwhile, and only a second finished pixel waits for m_axis_tready.
module iteration_count_colorizer_unit import icc_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int unsigned MAX_AA        = DEF_MAX_AA
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // iter_count[62:0] palette_index[72:63] palette_red[88:73]
  // palette_green[104:89] palette_blue[120:105], zero padded
  input  logic [127:0] s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // red[15:0] green[31:16] blue[47:32] alpha[63:48]
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [62:0]  cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(PALETTE_DEPTH);
  localparam int unsigned SW   = AW + 1;
  localparam int unsigned TW   = $clog2(MAX_AA * MAX_AA + 1);
  localparam int unsigned SUMW = 16 + TW;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GREY  = 4'd1;
  localparam logic [3:0] S_PREP  = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_PAL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_SEL   = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [62:0] max_iters_q;
  logic        iter_wide_q, grey_mode_q;
  logic [2:0]  aa_q;
  logic [5:0]  aux_q;
  logic [31:0] rot_q;
  logic [10:0] psize_q;
  logic [16:0] grey_scale_q;

  // datapath registers
  logic [62:0]     count_q;
  logic [63:0]     val_q;
  logic            esc_q;
  logic [63:0]     sh_q;
  logic [15:0]     col_r_q, col_g_q, col_b_q;
  logic [SUMW-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [TW-1:0]   cnt_q;
  logic            out_valid_q;
  logic [47:0]     out_rgb_q;

  // input fields
  logic        in_cmd;
  logic [62:0] in_count;
  logic [9:0]  in_pidx;
  logic [47:0] in_rgb;
  logic        in_fire;

  assign in_cmd   = s_axis_tuser;
  assign in_count = s_axis_tdata[62:0];
  assign in_pidx  = s_axis_tdata[72:63];
  assign in_rgb   = s_axis_tdata[120:73];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  // effective palette size and supersample total
  logic [31:0]     sz32;
  logic [SW-1:0]   size_eff;
  logic [3:0]      aa_eff;
  logic [TW-1:0]   total;

  always_comb begin
    sz32 = 32'(psize_q);
    if (sz32 == 32'd0) begin
      sz32 = 32'd1;
    end
    if (sz32 > PALETTE_DEPTH) begin
      sz32 = PALETTE_DEPTH;
    end
    size_eff = SW'(sz32);
    aa_eff = {1'b0, aa_q};
    if (aa_eff == 4'd0) begin
      aa_eff = 4'd1;
    end
    if (32'(aa_eff) > MAX_AA) begin
      aa_eff = 4'(MAX_AA);
    end
    total = TW'(8'(aa_eff) * 8'(aa_eff));
  end

  // limit compare, rotation and saturation
  logic [63:0] cnt_cmp, lim_cmp, cap, vsum, vsat;
  always_comb begin
    if (iter_wide_q) begin
      cnt_cmp = {1'b0, count_q};
      lim_cmp = {1'b0, max_iters_q};
      cap     = LIMIT_WIDE;
    end else begin
      cnt_cmp = {32'd0, count_q[31:0]};
      lim_cmp = {32'd0, max_iters_q[31:0]};
      cap     = LIMIT_NARROW;
    end
    vsum = cnt_cmp + {32'd0, rot_q};
    vsat = (vsum >= cap) ? cap - 64'd1 : vsum;
  end

  // grey ramp: low 16 bits of shifted count times scale
  logic [32:0] grey_prod;
  logic [15:0] grey_val;
  assign grey_prod = 33'(sh_q[15:0]) * 33'(grey_scale_q);
  assign grey_val  = grey_prod[15:0];

  // serial modulo by palette size
  logic            mod_start, mod_busy;
  logic [63:0]     mod_quot;
  logic [SW-1:0]   mod_rem;

  icc_sdiv #(.NumW(64), .DenW(SW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (sh_q),
    .den_i   (size_eff),
    .busy_o  (mod_busy),
    .quot_o  (mod_quot),
    .rem_o   (mod_rem)
  );

  // palette memory
  logic            pal_we;
  logic [47:0]     pal_rdata;

  assign pal_we = in_fire && in_cmd && (32'(in_pidx) < PALETTE_DEPTH);

  icc_ram #(.Width(48), .Depth(PALETTE_DEPTH)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (AW'(in_pidx)),
    .wdata_i (in_rgb),
    .raddr_i (AW'(mod_rem)),
    .rdata_o (pal_rdata)
  );

  // grey scale divide 65536 / max_iters, divisor taken from the write itself
  logic        grey_start, grey_busy;
  logic [16:0] grey_quot, grey_rem;

  icc_sdiv #(.NumW(17), .DenW(17)) u_grey (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (grey_start),
    .num_i   (GREY_NUM),
    .den_i   (cfg_wdata_i[16:0]),
    .busy_o  (grey_busy),
    .quot_o  (grey_quot),
    .rem_o   (grey_rem)
  );

  // per pixel average, three channels in parallel
  logic            div_start;
  logic [SUMW-1:0] nsum_r, nsum_g, nsum_b;
  logic [SUMW-1:0] q_r, q_g, q_b;
  logic [TW-1:0]   r_r, r_g, r_b;
  logic            busy_r, busy_g, busy_b;
  logic            last_sample;

  assign nsum_r = sum_r_q + SUMW'(col_r_q);
  assign nsum_g = sum_g_q + SUMW'(col_g_q);
  assign nsum_b = sum_b_q + SUMW'(col_b_q);
  assign last_sample = ({1'b0, cnt_q} + 1'b1) >= {1'b0, total};

  icc_sdiv #(.NumW(SUMW), .DenW(TW)) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .num_i (nsum_r),
    .den_i (total), .busy_o (busy_r), .quot_o (q_r), .rem_o (r_r)
  );
  icc_sdiv #(.NumW(SUMW), .DenW(TW)) u_div_g (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .num_i (nsum_g),
    .den_i (total), .busy_o (busy_g), .quot_o (q_g), .rem_o (r_g)
  );
  icc_sdiv #(.NumW(SUMW), .DenW(TW)) u_div_b (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (div_start), .num_i (nsum_b),
    .den_i (total), .busy_o (busy_b), .quot_o (q_b), .rem_o (r_b)
  );

  // config write decode
  logic cfg_max, cfg_aa;
  assign cfg_max = cfg_we_i && (cfg_addr_i == CFG_MAX_ITERS);
  assign cfg_aa  = cfg_we_i && (cfg_addr_i == CFG_AA_FACTOR);

  // grey divide only runs for limits 1..65536, others are settled at once
  assign grey_start = cfg_max && (cfg_wdata_i != 63'd0) &&
                      (cfg_wdata_i <= 63'd65536);

  // grey samples take their color from the product once the shift has landed
  logic grey_path;
  assign grey_path = !esc_q && grey_mode_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    mod_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (grey_start) begin
          state_d = S_GREY;
        end else if (in_fire && !in_cmd) begin
          state_d = S_PREP;
        end
      end
      S_GREY: begin
        if (!grey_busy) begin
          state_d = S_IDLE;
        end
      end
      S_PREP:  state_d = S_SHIFT;
      S_SHIFT: state_d = S_SEL;
      S_SEL: begin
        if (esc_q || grey_mode_q) begin
          state_d = S_ACC;
        end else begin
          mod_start = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          state_d = S_RD;
        end
      end
      S_RD:  state_d = S_PAL;
      S_PAL: state_d = S_ACC;
      S_ACC: begin
        if (last_sample) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (!busy_r && !busy_g && !busy_b) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_iters_q  <= MAX_ITERS_RST;
      iter_wide_q  <= 1'b0;
      aa_q         <= 3'd1;
      grey_mode_q  <= 1'b0;
      aux_q        <= '0;
      rot_q        <= '0;
      psize_q      <= 11'd1;
      grey_scale_q <= GREY_RST;
      sum_r_q      <= '0;
      sum_g_q      <= '0;
      sum_b_q      <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MAX_ITERS: max_iters_q <= cfg_wdata_i;
          CFG_ITER_WIDE: iter_wide_q <= cfg_wdata_i[0];
          CFG_AA_FACTOR: aa_q        <= cfg_wdata_i[2:0];
          CFG_GREY_MODE: grey_mode_q <= cfg_wdata_i[0];
          CFG_AUX_DEPTH: aux_q       <= cfg_wdata_i[5:0];
          CFG_ROTATION:  rot_q       <= cfg_wdata_i[31:0];
          CFG_PAL_SIZE:  psize_q     <= cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      if (cfg_max) begin
        if (cfg_wdata_i == 63'd0) begin
          grey_scale_q <= GREY_NUM;
        end else if (cfg_wdata_i > 63'd65536) begin
          grey_scale_q <= 17'd1;
        end
      end
      if (state_q == S_GREY && !grey_busy) begin
        grey_scale_q <= grey_quot;
      end
      // pixel accumulation; a factor write restarts the pixel
      if (cfg_aa || (state_q == S_ACC && last_sample)) begin
        sum_r_q <= '0;
        sum_g_q <= '0;
        sum_b_q <= '0;
        cnt_q   <= '0;
      end else if (state_q == S_ACC) begin
        sum_r_q <= nsum_r;
        sum_g_q <= nsum_g;
        sum_b_q <= nsum_b;
        cnt_q   <= cnt_q + 1'b1;
      end
      if (state_q == S_OUT && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      count_q <= in_count;
    end
    if (state_q == S_PREP) begin
      esc_q <= (cnt_cmp >= lim_cmp);
      val_q <= vsat;
    end
    if (state_q == S_SHIFT) begin
      sh_q <= val_q >> aux_q;
    end
    if (state_q == S_SHIFT) begin
      col_r_q <= '0;
      col_g_q <= '0;
      col_b_q <= '0;
    end
    if (state_q == S_SEL && grey_path) begin
      col_r_q <= grey_val;
      col_g_q <= grey_val;
      col_b_q <= grey_val;
    end
    if (state_q == S_PAL) begin
      col_r_q <= pal_rdata[15:0];
      col_g_q <= pal_rdata[31:16];
      col_b_q <= pal_rdata[47:32];
    end
    if (state_q == S_OUT && state_d == S_IDLE) begin
      out_rgb_q <= {q_b[15:0], q_g[15:0], q_r[15:0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ALPHA_OPAQUE, out_rgb_q};

endmodule

/* bench/tb_top.sv */
// self-checking bench for iteration_count_colorizer_unit: stream-driven
// samples and palette writes checked against an in-bench pixel predictor
// depends on icc_pkg and the colorizer rtl
`timescale 1ns / 100ps

module tb_top;
  import icc_pkg::*;

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } pixel_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // iter_count[62:0] palette_index[72:63] red[88:73] green[104:89] blue[120:105]
  logic [127:0] s_axis_tdata = '0;
  // command (0 sample, 1 palette write)
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // red[15:0] green[31:16] blue[47:32] alpha[63:48]
  logic [63:0]  m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_addr_i = '0;
  logic [62:0]  cfg_wdata_i = '0;

  localparam bit CMD_SAMPLE = 1'b0;
  localparam bit CMD_PAL_WR = 1'b1;
  // settle time for a palette-mode sample plus the per-pixel divide, with margin
  localparam int SETTLE_CYCLES = 200;

  iteration_count_colorizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow state of the colorizer
  logic [47:0] pal_shadow [DEF_PALETTE_DEPTH];
  bit          pal_written [DEF_PALETTE_DEPTH];
  logic [31:0] acc_red, acc_green, acc_blue;
  int unsigned acc_samples;
  logic [16:0] grey_step;
  logic [62:0] lim_iters;
  bit          wide_counts;
  logic [2:0]  ss_factor;
  bit          grey_on;
  logic [5:0]  shift_depth;
  logic [31:0] rotation;
  logic [10:0] pal_size;

  pixel_t pixel_q[$];
  int     errors = 0;
  bit     no_idle = 1'b0;
  int     hold_left = 0;

  // grey ramp step: 65536 / max_iters, never zero
  function automatic logic [16:0] grey_step_for(logic [62:0] mi);
    logic [62:0] q;
    if (mi == 0) return 17'h10000;
    q = 63'd65536 / mi;
    if (q == 0) q = 1;
    return q[16:0];
  endfunction

  // rotated, saturated and shifted count; flag says whether it is colored at all
  function automatic logic [63:0] shifted_count(logic [62:0] cnt, output bit lit);
    logic [63:0] c, l, cap, v;
    c = wide_counts ? {1'b0, cnt} : {32'd0, cnt[31:0]};
    l = wide_counts ? {1'b0, lim_iters} : {32'd0, lim_iters[31:0]};
    cap = wide_counts ? LIMIT_WIDE : LIMIT_NARROW;
    lit = (c < l);
    v = c + {32'd0, rotation};
    if (v >= cap) v = cap - 1;
    return v >> shift_depth;
  endfunction

  // palette entry a sample reads, or -1 if it reads none
  function automatic int pal_index_of(logic [62:0] cnt);
    bit lit;
    logic [63:0] sh, sz;
    sh = shifted_count(cnt, lit);
    if (!lit || grey_on) return -1;
    sz = (pal_size == 0) ? 1 : (pal_size > DEF_PALETTE_DEPTH) ? DEF_PALETTE_DEPTH : pal_size;
    return int'(sh % sz);
  endfunction

  // {b, g, r} contribution of one sample
  function automatic logic [47:0] sample_color(logic [62:0] cnt);
    bit lit;
    logic [63:0] sh, prod;
    int idx;
    sh = shifted_count(cnt, lit);
    if (!lit) return '0;
    if (grey_on) begin
      prod = sh * {47'd0, grey_step};
      return {3{prod[15:0]}};
    end
    idx = pal_index_of(cnt);
    return pal_shadow[idx];
  endfunction

  function automatic int unsigned ss_total();
    int unsigned a;
    a = (ss_factor == 0) ? 1 : (ss_factor > DEF_MAX_AA) ? DEF_MAX_AA : ss_factor;
    return a * a;
  endfunction

  function automatic void clear_pixel();
    acc_red = 0;
    acc_green = 0;
    acc_blue = 0;
    acc_samples = 0;
  endfunction

  // one transaction on s_axis, with random idle cycles before it
  task automatic push_item(bit cmd, logic [127:0] data);
    while (!no_idle && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_palette(logic [9:0] idx, logic [47:0] bgr);
    pal_shadow[idx] = bgr;
    pal_written[idx] = 1'b1;
    push_item(CMD_PAL_WR, {7'd0, bgr, idx, 63'd0});
  endtask

  // a sample; an unwritten palette entry it would read is filled first
  task automatic send_sample(logic [62:0] cnt);
    int idx;
    logic [47:0] col;
    pixel_t px;
    int unsigned tot;
    idx = pal_index_of(cnt);
    if (idx >= 0 && !pal_written[idx])
      write_palette(idx[9:0], 48'({$urandom, $urandom}));
    col = sample_color(cnt);
    acc_red   += col[15:0];
    acc_green += col[31:16];
    acc_blue  += col[47:32];
    acc_samples++;
    tot = ss_total();
    if (acc_samples >= tot) begin
      px.red   = 16'(acc_red / tot);
      px.green = 16'(acc_green / tot);
      px.blue  = 16'(acc_blue / tot);
      px.alpha = ALPHA_OPAQUE;
      pixel_q.insert(pixel_q.size(), px);
      clear_pixel();
    end
    push_item(CMD_SAMPLE, {55'd0, 10'($urandom_range(1023)), cnt});
  endtask

  // quiet the input, drain results, and let a result-less sample finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [62:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (addr)
      CFG_MAX_ITERS: begin
        lim_iters = val;
        grey_step = grey_step_for(val);
      end
      CFG_ITER_WIDE: wide_counts = val[0];
      CFG_AA_FACTOR: begin
        ss_factor = val[2:0];
        clear_pixel();
      end
      CFG_GREY_MODE: grey_on = val[0];
      CFG_AUX_DEPTH: shift_depth = val[5:0];
      CFG_ROTATION:  rotation = val[31:0];
      CFG_PAL_SIZE:  pal_size = val[10:0];
      default: ;
    endcase
  endtask

  function automatic logic [62:0] rand_count();
    logic [62:0] r;
    r = 63'({$urandom, $urandom});
    case ($urandom_range(5))
      0: return 63'($urandom_range(0, 300));
      1: return r;
      2: return {31'd0, r[31:0]};
      3: return lim_iters + 63'($signed($urandom_range(0, 4)) - 2);
      4: return 63'd2147483646 + 63'($urandom_range(0, 3)) - 63'd2;
      default: return (lim_iters[31:0] == 0) ? r : {31'd0, $urandom} % {31'd0, lim_iters[31:0]};
    endcase
  endfunction

  function automatic logic [62:0] rand_limit();
    case ($urandom_range(5))
      0: return 63'd1;
      1: return 63'd256;
      2: return 63'($urandom_range(2, 5000));
      3: return {31'd0, $urandom};
      4: return 63'({$urandom, $urandom});
      default: return 63'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // extremes of each field, each register, and the listed corner cases
  task automatic test_directed();
    write_palette(10'd0, 48'h0);
    write_palette(10'd1023, 48'hFFFF_FFFF_FFFF);
    send_sample(63'd0);
    send_sample(63'd255);
    send_sample(63'd256);
    send_sample(63'h7FFF_FFFF_FFFF_FFFF);
    wait_idle();
    write_reg(CFG_PAL_SIZE, 63'd1024);
    write_reg(CFG_ROTATION, 63'd1023);
    send_sample(63'd0);
    send_sample(63'd1);
    wait_idle();
    // max aa, palette write in the middle of a pixel
    write_reg(CFG_AA_FACTOR, 63'd4);
    write_reg(CFG_ROTATION, 63'hFFFF_FFFF);
    write_reg(CFG_AUX_DEPTH, 63'd63);
    repeat (8) send_sample(63'd5);
    write_palette(10'd0, 48'h1234_5678_9ABC);
    repeat (8) send_sample(63'd300);
    wait_idle();
    // factor above the max and zero; size zero and beyond depth
    write_reg(CFG_AA_FACTOR, 63'd7);
    write_reg(CFG_PAL_SIZE, 63'd0);
    write_reg(CFG_AUX_DEPTH, 63'd0);
    write_reg(CFG_ROTATION, 63'd0);
    repeat (16) send_sample(63'd3);
    wait_idle();
    write_reg(CFG_AA_FACTOR, 63'd0);
    write_reg(CFG_PAL_SIZE, 63'd2047);
    send_sample(63'd77);
    wait_idle();
    // grey ramp, zero limit, wide counts with full limit
    write_reg(CFG_GREY_MODE, 63'd1);
    write_reg(CFG_MAX_ITERS, 63'd0);
    send_sample(63'd10);
    wait_idle();
    write_reg(CFG_ITER_WIDE, 63'd1);
    write_reg(CFG_MAX_ITERS, 63'h7FFF_FFFF_FFFF_FFFF);
    send_sample(63'h7FFF_FFFF_FFFF_FFFE);
    send_sample(63'd65535);
    wait_idle();
  endtask

  // random phases, each under a freshly drawn register setting
  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_reg(CFG_MAX_ITERS, rand_limit());
      write_reg(CFG_ITER_WIDE, 63'($urandom_range(1)));
      write_reg(CFG_AA_FACTOR,
                63'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 2)));
      write_reg(CFG_GREY_MODE, 63'($urandom_range(1)));
      write_reg(CFG_AUX_DEPTH,
                63'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(4)));
      write_reg(CFG_ROTATION,
                63'(($urandom_range(1) == 0) ? $urandom : $urandom_range(50)));
      write_reg(CFG_PAL_SIZE,
                63'(($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(1, 16)));
      no_idle = (p == 2);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(9) == 0)
          write_palette(10'($urandom_range(1023)), 48'({$urandom, $urandom}));
        else
          send_sample(rand_count());
      end
      wait_idle();
      no_idle = 1'b0;
    end
  endtask

  // receiver holds off long while fast grey pixels keep coming
  task automatic test_backpressure();
    write_reg(CFG_AA_FACTOR, 63'd1);
    write_reg(CFG_GREY_MODE, 63'd1);
    write_reg(CFG_MAX_ITERS, 63'd1000);
    hold_left = 500;
    for (int i = 0; i < 60; i++) send_sample(63'($urandom_range(0, 1200)));
    wait_idle();
  endtask

  // result checker
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pixel_q[0];
        pixel_q.delete(0);
        if (got.red !== want.red)
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
        if (got.alpha !== want.alpha)
          $display("%0t: alpha expected %h actual %h", $time, want.alpha, got.alpha);
        if (got !== want) errors++;
      end
    end
  end

  // receiver ready, with random stalls and a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    clear_pixel();
    lim_iters = MAX_ITERS_RST;
    grey_step = GREY_RST;
    wide_counts = 1'b0;
    ss_factor = 3'd1;
    grey_on = 1'b0;
    shift_depth = '0;
    rotation = '0;
    pal_size = 11'd1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (20) @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_phases(10, 145);
    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
